>>> src/bdtd_pkg.sv
// shared types and constants of the byte order mark text decoder
package bdtd_pkg;

    localparam logic [7:0] BYTE_EF       = 8'hEF;
    localparam logic [7:0] BYTE_BB       = 8'hBB;
    localparam logic [7:0] BYTE_BF       = 8'hBF;
    localparam logic [7:0] BYTE_FF       = 8'hFF;
    localparam logic [7:0] BYTE_FE       = 8'hFE;
    localparam logic [7:0] LEAD_HI_MASK  = 8'h80;
    localparam logic [7:0] LEAD3_MASK    = 8'hE0;
    localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
    localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
    localparam logic [7:0] CONT_PAYLOAD  = 8'h3F;

    localparam int MAX_UNITS   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_FIRST   = 4'b0001,
        PH_ONE     = 4'b0010,
        PH_EF_BB   = 4'b0100,
        PH_DECIDED = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_UTF8  = 2'd1,
        MODE_U16LE = 2'd2,
        MODE_U16BE = 2'd3
    } mode_t;

    // results caused by one byte: n_units code units, then an end word if end_flag
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [1:0]                 n_units;
        logic                       end_flag;
    } group_t;

endpackage

>>> src/bom_detect_text_decoder.sv
// top level of the byte order mark text decoder
// usage:
//   input channel s_*: one file byte per word (s_data_byte) with s_frame_last
//   on the final byte of each file. the first bytes are held to look for a
//   mark (EF BB BF utf-8, FF FE utf-16 le, FE FF utf-16 be, else 8-bit
//   passthrough); the mark itself is never sent.
//   result channel m_*: one word per code unit (m_has_unit high) and one
//   closing word per file (m_end_of_text high, unit zero).
//   order: a byte's first result word is written into the queue, then
//   loaded into the back output register, and only then offered.
//   throughput: one byte per cycle while each byte causes at most one result
//   and m_ready stays high; a byte causing more than one word holds the back
//   end until all are sent, the front keeps taking bytes until the two-group queue fills.
//   reset: aresetn (synchronous, active low) returns to mark detection for
//   a new file and drops any queued words.
//   receiver stall: m_valid and the word hold until m_ready; s_ready falls
//   only when the queue is full.
module bom_detect_text_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_has_unit,
    output logic        m_end_of_text
);

    bdtd_pkg::group_t push_group;
    bdtd_pkg::group_t pop_group;
    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;

    bdtd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_frame_last (s_frame_last),
        .q_full       (full),
        .q_push       (push),
        .q_group      (push_group)
    );

    bdtd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .full       (full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_group    (pop_group)
    );

    bdtd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_group       (pop_group),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_has_unit    (m_has_unit),
        .m_end_of_text (m_end_of_text)
    );

endmodule

>>> src/bdtd_front.sv
// front end: mark detection and decoding of one byte into a group of result words
module bdtd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_frame_last,
    input  logic             q_full,
    output logic             q_push,
    output bdtd_pkg::group_t q_group
);

    bdtd_pkg::phase_t phase_reg, phase_next;
    bdtd_pkg::mode_t  mode_reg, mode_next;
    logic [15:0]      held_reg, held_next;
    logic [15:0]      acc_reg, acc_next;
    logic [1:0]       rem_reg, rem_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             ended_reg, ended_next;

    logic [bdtd_pkg::MAX_UNITS-1:0][15:0] cand;
    logic [1:0]       n_cand;
    logic [1:0]       n_units;
    logic             stop;
    logic             end_flag;
    logic             accept;
    logic [7:0]       b;
    logic [15:0]      acc_upd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data_byte;

    always_comb begin
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        held_next       = held_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        cand            = '0;
        n_cand          = 2'd0;
        acc_upd         = 16'd0;

        if (!ended_reg) begin
            unique case (phase_reg)
                bdtd_pkg::PH_FIRST: begin
                    held_next  = {8'd0, b};
                    phase_next = bdtd_pkg::PH_ONE;
                    if (s_frame_last) begin
                        mode_next  = bdtd_pkg::MODE_PASS;
                        phase_next = bdtd_pkg::PH_DECIDED;
                        cand[0]    = {8'd0, b};
                        n_cand     = 2'd1;
                    end
                end
                bdtd_pkg::PH_ONE: begin
                    phase_next = bdtd_pkg::PH_DECIDED;
                    priority if (held_reg[7:0] == bdtd_pkg::BYTE_FF
                                 && b == bdtd_pkg::BYTE_FE) begin
                        mode_next = bdtd_pkg::MODE_U16LE;
                    end else if (held_reg[7:0] == bdtd_pkg::BYTE_FE
                                 && b == bdtd_pkg::BYTE_FF) begin
                        mode_next = bdtd_pkg::MODE_U16BE;
                    end else if (held_reg[7:0] == bdtd_pkg::BYTE_EF
                                 && b == bdtd_pkg::BYTE_BB && !s_frame_last) begin
                        held_next  = {b, held_reg[7:0]};
                        phase_next = bdtd_pkg::PH_EF_BB;
                    end else begin
                        mode_next = bdtd_pkg::MODE_PASS;
                        cand[0]   = {8'd0, held_reg[7:0]};
                        cand[1]   = {8'd0, b};
                        n_cand    = 2'd2;
                    end
                end
                bdtd_pkg::PH_EF_BB: begin
                    phase_next = bdtd_pkg::PH_DECIDED;
                    if (b == bdtd_pkg::BYTE_BF) begin
                        mode_next = bdtd_pkg::MODE_UTF8;
                    end else begin
                        mode_next = bdtd_pkg::MODE_PASS;
                        cand[0]   = {8'd0, held_reg[7:0]};
                        cand[1]   = {8'd0, held_reg[15:8]};
                        cand[2]   = {8'd0, b};
                        n_cand    = 2'd3;
                    end
                end
                bdtd_pkg::PH_DECIDED: begin
                    unique case (mode_reg)
                        bdtd_pkg::MODE_PASS: begin
                            cand[0] = {8'd0, b};
                            n_cand  = 2'd1;
                        end
                        bdtd_pkg::MODE_UTF8: begin
                            priority if (rem_reg != 2'd0) begin
                                rem_next = rem_reg - 2'd1;
                                if (rem_next == 2'd0) begin
                                    acc_upd = acc_reg | {10'd0, b[5:0] & bdtd_pkg::CONT_PAYLOAD[5:0]};
                                end else begin
                                    acc_upd = acc_reg
                                        | {4'd0, b[5:0] & bdtd_pkg::CONT_PAYLOAD[5:0], 6'd0};
                                end
                                acc_next = acc_upd;
                                if (rem_next == 2'd0) begin
                                    cand[0] = acc_upd;
                                    n_cand  = 2'd1;
                                end
                            end else if ((b & bdtd_pkg::LEAD_HI_MASK) == 8'd0) begin
                                cand[0] = {8'd0, b};
                                n_cand  = 2'd1;
                            end else if ((b & bdtd_pkg::LEAD3_MASK)
                                         == bdtd_pkg::LEAD3_MASK) begin
                                acc_next = {b[3:0] & bdtd_pkg::LEAD3_PAYLOAD[3:0], 12'd0};
                                rem_next = 2'd2;
                            end else begin
                                acc_next = {5'd0, b[4:0] & bdtd_pkg::LEAD2_PAYLOAD[4:0], 6'd0};
                                rem_next = 2'd1;
                            end
                        end
                        bdtd_pkg::MODE_U16LE, bdtd_pkg::MODE_U16BE: begin
                            if (!pend_valid_reg) begin
                                pend_valid_next = 1'b1;
                                pend_byte_next  = b;
                            end else begin
                                pend_valid_next = 1'b0;
                                pend_byte_next  = 8'd0;
                                cand[0] = (mode_reg == bdtd_pkg::MODE_U16LE)
                                        ? {b, pend_byte_reg} : {pend_byte_reg, b};
                                n_cand  = 2'd1;
                            end
                        end
                        default: begin
                            n_cand = 2'd0;
                        end
                    endcase
                end
                default: begin
                    phase_next = bdtd_pkg::PH_FIRST;
                end
            endcase
        end

        // a zero unit closes the text in its place
        n_units  = 2'd0;
        stop     = 1'b0;
        for (int i = 0; i < bdtd_pkg::MAX_UNITS; i++) begin
            if (2'(i) < n_cand && !stop) begin
                if (cand[i] == 16'd0) begin
                    stop = 1'b1;
                end else begin
                    n_units = n_units + 2'd1;
                end
            end
        end
        end_flag   = stop || (s_frame_last && !ended_reg);
        ended_next = ended_reg || stop;

        if (s_frame_last) begin
            phase_next      = bdtd_pkg::PH_FIRST;
            mode_next       = bdtd_pkg::MODE_PASS;
            held_next       = 16'd0;
            acc_next        = 16'd0;
            rem_next        = 2'd0;
            pend_valid_next = 1'b0;
            pend_byte_next  = 8'd0;
            ended_next      = 1'b0;
        end

        q_group.units    = cand;
        q_group.n_units  = n_units;
        q_group.end_flag = end_flag;
    end

    assign q_push = accept && (n_units != 2'd0 || end_flag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= bdtd_pkg::PH_FIRST;
            mode_reg       <= bdtd_pkg::MODE_PASS;
            held_reg       <= 16'd0;
            acc_reg        <= 16'd0;
            rem_reg        <= 2'd0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= 8'd0;
            ended_reg      <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            acc_reg        <= acc_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            ended_reg      <= ended_next;
        end
    end

endmodule

>>> src/bdtd_queue.sv
// short queue of result groups between front and back
module bdtd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  bdtd_pkg::group_t push_group,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output bdtd_pkg::group_t q_group
);

    localparam int PW = bdtd_pkg::QPTR_W;
    localparam int CW = bdtd_pkg::QCNT_W;

    bdtd_pkg::group_t mem_reg [bdtd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(bdtd_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_group = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(bdtd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(bdtd_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + PW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(bdtd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("group pushed into a full queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not follow a push");

endmodule

>>> src/bdtd_back.sv
// back end: sends the words of each queued group out one per cycle while m_ready is high
module bdtd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  bdtd_pkg::group_t q_group,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [15:0]      m_code_unit,
    output logic             m_has_unit,
    output logic             m_end_of_text
);

    bdtd_pkg::group_t cur_reg;
    logic [1:0]       idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic [2:0]       total;
    logic             last_word;
    logic             take;
    logic             is_unit;

    assign total     = {1'b0, cur_reg.n_units} + {2'd0, cur_reg.end_flag};
    assign last_word = ({1'b0, idx_reg} + 3'd1) == total;
    assign take      = !busy_reg || (m_ready && last_word);
    assign q_pop     = q_valid && take;

    assign m_valid   = busy_reg;
    assign is_unit   = idx_reg < cur_reg.n_units;

    always_comb begin
        unique case (idx_reg)
            2'd0:    m_code_unit = cur_reg.units[0];
            2'd1:    m_code_unit = cur_reg.units[1];
            2'd2:    m_code_unit = cur_reg.units[2];
            default: m_code_unit = 16'd0;
        endcase
        if (!is_unit) begin
            m_code_unit = 16'd0;
        end
    end

    assign m_has_unit    = is_unit;
    assign m_end_of_text = !is_unit;

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        priority if (q_pop) begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg && m_ready) begin
            if (last_word) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_group;
        end
    end

    a_group_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> total != 3'd0)
        else $error("empty group loaded");

    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_unit) |-> m_code_unit != 16'd0)
        else $error("zero code unit sent as a character");

    a_stays_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_ready && !last_word) |=> busy_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("group cut short");

endmodule

>>> dv/decoded_unit_checker.sv
// channel monitor for the text decoder: predicts every result word and compares
module decoded_unit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_code_unit,
    input  logic        m_has_unit,
    input  logic        m_end_of_text,
    output int          mismatch_count,
    output int          words_pending
);

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_text;
    } result_word_t;

    result_word_t expected_words[$];
    int           fails = 0;

    bdtd_pkg::phase_t mark_ph = bdtd_pkg::PH_FIRST;
    bdtd_pkg::mode_t  enc_mode = bdtd_pkg::MODE_PASS;
    logic [15:0]  held_bytes = '0;
    logic [15:0]  utf8_acc = '0;
    logic [1:0]   cont_left = '0;
    logic [8:0]   half_byte = '0;
    logic         text_done = 1'b0;

    task automatic restart_file();
        mark_ph    = bdtd_pkg::PH_FIRST;
        enc_mode   = bdtd_pkg::MODE_PASS;
        held_bytes = '0;
        utf8_acc   = '0;
        cont_left  = '0;
        half_byte  = '0;
        text_done  = 1'b0;
    endtask

    task automatic close_text();
        result_word_t w;
        w.code_unit   = 16'h0000;
        w.has_unit    = 1'b0;
        w.end_of_text = 1'b1;
        expected_words.push_back(w);
        text_done = 1'b1;
    endtask

    // a zero unit closes the text in its place
    task automatic emit_code_unit(input logic [15:0] u);
        result_word_t w;
        if (!text_done) begin
            if (u == 16'h0000) begin
                close_text();
            end else begin
                w.code_unit   = u;
                w.has_unit    = 1'b1;
                w.end_of_text = 1'b0;
                expected_words.push_back(w);
            end
        end
    endtask

    task automatic decode_body_byte(input logic [7:0] b);
        logic [15:0] piece;
        case (enc_mode)
            bdtd_pkg::MODE_PASS: begin
                emit_code_unit({8'h00, b});
            end
            bdtd_pkg::MODE_UTF8: begin
                if (cont_left != 2'd0) begin
                    cont_left = cont_left - 2'd1;
                    piece     = {8'h00, b & bdtd_pkg::CONT_PAYLOAD};
                    utf8_acc  = utf8_acc | (piece << (6 * cont_left));
                    if (cont_left == 2'd0)
                        emit_code_unit(utf8_acc);
                end else if ((b & bdtd_pkg::LEAD_HI_MASK) == 8'h00) begin
                    emit_code_unit({8'h00, b});
                end else if ((b & bdtd_pkg::LEAD3_MASK) == bdtd_pkg::LEAD3_MASK) begin
                    utf8_acc  = {8'h00, b & bdtd_pkg::LEAD3_PAYLOAD} << 12;
                    cont_left = 2'd2;
                end else begin
                    utf8_acc  = {8'h00, b & bdtd_pkg::LEAD2_PAYLOAD} << 6;
                    cont_left = 2'd1;
                end
            end
            default: begin
                if (!half_byte[8]) begin
                    half_byte = {1'b1, b};
                end else begin
                    if (enc_mode == bdtd_pkg::MODE_U16LE)
                        emit_code_unit({b, half_byte[7:0]});
                    else
                        emit_code_unit({half_byte[7:0], b});
                    half_byte = '0;
                end
            end
        endcase
    endtask

    task automatic decode_file_byte(input logic [7:0] b, input logic last);
        logic [7:0] lead_byte;
        if (!text_done) begin
            case (mark_ph)
                bdtd_pkg::PH_FIRST: begin
                    held_bytes = {8'h00, b};
                    mark_ph    = bdtd_pkg::PH_ONE;
                    if (last) begin
                        enc_mode = bdtd_pkg::MODE_PASS;
                        mark_ph  = bdtd_pkg::PH_DECIDED;
                        emit_code_unit({8'h00, b});
                    end
                end
                bdtd_pkg::PH_ONE: begin
                    lead_byte = held_bytes[7:0];
                    mark_ph   = bdtd_pkg::PH_DECIDED;
                    if (lead_byte == bdtd_pkg::BYTE_FF && b == bdtd_pkg::BYTE_FE) begin
                        enc_mode = bdtd_pkg::MODE_U16LE;
                    end else if (lead_byte == bdtd_pkg::BYTE_FE
                                 && b == bdtd_pkg::BYTE_FF) begin
                        enc_mode = bdtd_pkg::MODE_U16BE;
                    end else if (lead_byte == bdtd_pkg::BYTE_EF
                                 && b == bdtd_pkg::BYTE_BB && !last) begin
                        held_bytes[15:8] = b;
                        mark_ph          = bdtd_pkg::PH_EF_BB;
                    end else begin
                        enc_mode = bdtd_pkg::MODE_PASS;
                        emit_code_unit({8'h00, lead_byte});
                        emit_code_unit({8'h00, b});
                    end
                end
                bdtd_pkg::PH_EF_BB: begin
                    mark_ph = bdtd_pkg::PH_DECIDED;
                    if (b == bdtd_pkg::BYTE_BF) begin
                        enc_mode = bdtd_pkg::MODE_UTF8;
                    end else begin
                        enc_mode = bdtd_pkg::MODE_PASS;
                        emit_code_unit({8'h00, held_bytes[7:0]});
                        emit_code_unit({8'h00, held_bytes[15:8]});
                        emit_code_unit({8'h00, b});
                    end
                end
                default: begin
                    decode_body_byte(b);
                end
            endcase
        end
        if (last) begin
            if (!text_done)
                close_text();
            restart_file();
        end
    endtask

    always @(posedge aclk) begin
        result_word_t want;
        if (!aresetn) begin
            restart_file();
            expected_words.delete();
        end else begin
            // a word leaving now belongs to an earlier byte, so check before predicting
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: code_unit %h has_unit %b end_of_text %b",
                           m_code_unit, m_has_unit, m_end_of_text);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, got %h", want.code_unit, m_code_unit);
                        fails++;
                    end
                    if (m_has_unit !== want.has_unit) begin
                        $error("has_unit: expected %b, got %b", want.has_unit, m_has_unit);
                        fails++;
                    end
                    if (m_end_of_text !== want.end_of_text) begin
                        $error("end_of_text: expected %b, got %b",
                               want.end_of_text, m_end_of_text);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready)
                decode_file_byte(s_data_byte, s_frame_last);
        end
        words_pending  <= expected_words.size();
        mismatch_count <= fails;
    end

endmodule

>>> dv/tb.sv
// testbench top for the text decoder: file stimulus, handshake idling and verdict
module tb;

    typedef enum int {
        FILE_UTF8,
        FILE_U16,
        FILE_PLAIN,
        FILE_BROKEN_MARK,
        FILE_NOISE
    } file_kind_t;

    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_frame_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_has_unit;
    logic        m_end_of_text;
    int          mismatch_count;
    int          words_pending;

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic        sink_hold = 1'b0;
    logic        pressure_go = 1'b0;
    int          bytes_sent = 0;
    logic [7:0]  file_bytes[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bom_detect_text_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_last  (s_frame_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_has_unit    (m_has_unit),
        .m_end_of_text (m_end_of_text)
    );

    decoded_unit_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_last   (s_frame_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_unit    (m_code_unit),
        .m_has_unit     (m_has_unit),
        .m_end_of_text  (m_end_of_text),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    always @(posedge aclk) begin
        if (sink_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // long receiver hold-off so the decoder fills up and stalls its input
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin
        #3000000;
        $display("** bom_detect_text_decoder: FAILED **");
        $finish;
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        logic [7:0] b;
        b = 8'($urandom_range(hi, lo));
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_frame_last <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic add_utf8_char();
        int len;
        len = $urandom_range(2);
        if (len == 0) begin
            file_bytes.push_back(rand_byte(1, 127));
        end else if (len == 1) begin
            file_bytes.push_back(rand_byte(8'h80, 8'hDF));
            file_bytes.push_back(rand_byte(0, 255));
        end else begin
            file_bytes.push_back(rand_byte(8'hE0, 8'hFF));
            file_bytes.push_back(rand_byte(0, 255));
            file_bytes.push_back(rand_byte(0, 255));
        end
    endtask

    task automatic make_random_file();
        int          pick;
        int          n_chars;
        file_kind_t  kind;
        logic [15:0] pair;
        logic [7:0]  b;
        pick    = $urandom_range(99);
        n_chars = $urandom_range(8);
        if (pick < 30)
            kind = FILE_UTF8;
        else if (pick < 60)
            kind = FILE_U16;
        else if (pick < 75)
            kind = FILE_PLAIN;
        else if (pick < 85)
            kind = FILE_BROKEN_MARK;
        else
            kind = FILE_NOISE;
        case (kind)
            FILE_UTF8: begin
                file_bytes.push_back(bdtd_pkg::BYTE_EF);
                file_bytes.push_back(bdtd_pkg::BYTE_BB);
                file_bytes.push_back(bdtd_pkg::BYTE_BF);
                repeat (n_chars) add_utf8_char();
                // sequence cut off by the end of the file
                if ($urandom_range(3) == 0)
                    file_bytes.push_back(rand_byte(8'h80, 8'hFF));
            end
            FILE_U16: begin
                if ($urandom_range(1) == 0) begin
                    file_bytes.push_back(bdtd_pkg::BYTE_FF);
                    file_bytes.push_back(bdtd_pkg::BYTE_FE);
                end else begin
                    file_bytes.push_back(bdtd_pkg::BYTE_FE);
                    file_bytes.push_back(bdtd_pkg::BYTE_FF);
                end
                repeat (n_chars) begin
                    pair = 16'($urandom_range(16'hFFFF, 1));
                    file_bytes.push_back(pair[7:0]);
                    file_bytes.push_back(pair[15:8]);
                end
                if ($urandom_range(3) == 0)
                    file_bytes.push_back(rand_byte(0, 255));
            end
            FILE_PLAIN: begin
                do
                    b = rand_byte(1, 255);
                while (b == bdtd_pkg::BYTE_EF || b == bdtd_pkg::BYTE_FF
                       || b == bdtd_pkg::BYTE_FE);
                file_bytes.push_back(b);
                repeat (n_chars) file_bytes.push_back(rand_byte(1, 255));
            end
            FILE_BROKEN_MARK: begin
                pick = $urandom_range(3);
                if (pick == 0) begin
                    file_bytes.push_back(bdtd_pkg::BYTE_EF);
                    file_bytes.push_back(bdtd_pkg::BYTE_BB);
                    do
                        b = rand_byte(1, 255);
                    while (b == bdtd_pkg::BYTE_BF);
                end else if (pick == 1) begin
                    file_bytes.push_back(bdtd_pkg::BYTE_EF);
                    do
                        b = rand_byte(1, 255);
                    while (b == bdtd_pkg::BYTE_BB);
                end else if (pick == 2) begin
                    file_bytes.push_back(bdtd_pkg::BYTE_FF);
                    do
                        b = rand_byte(1, 255);
                    while (b == bdtd_pkg::BYTE_FE);
                end else begin
                    file_bytes.push_back(bdtd_pkg::BYTE_FE);
                    do
                        b = rand_byte(1, 255);
                    while (b == bdtd_pkg::BYTE_FF);
                end
                file_bytes.push_back(b);
                repeat (n_chars) file_bytes.push_back(rand_byte(1, 255));
            end
            default: begin
                repeat ($urandom_range(6, 1)) file_bytes.push_back(rand_byte(0, 255));
            end
        endcase
    endtask

    initial begin
        int target;
        int guard;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // utf-8 with two- and three-byte characters, then a zero unit
        file_bytes = '{bdtd_pkg::BYTE_EF, bdtd_pkg::BYTE_BB, bdtd_pkg::BYTE_BF,
                       8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h41, 8'h00};
        send_file();
        // big endian, all-ones unit
        file_bytes = '{bdtd_pkg::BYTE_FE, bdtd_pkg::BYTE_FF, 8'hFF, 8'hFF};
        send_file();
        // little endian zero pair, then a byte after the end
        file_bytes = '{bdtd_pkg::BYTE_FF, bdtd_pkg::BYTE_FE, 8'h00, 8'h00, 8'h56};
        send_file();
        // short files
        file_bytes = '{8'hFF};
        send_file();
        file_bytes = '{bdtd_pkg::BYTE_EF, bdtd_pkg::BYTE_BB};
        send_file();
        file_bytes = '{bdtd_pkg::BYTE_EF, bdtd_pkg::BYTE_BB, 8'h41};
        send_file();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1: begin
                    src_idle_pct   = 68;
                    sink_stall_pct <= 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 68;
                end
                default: begin
                    src_idle_pct   = 10;
                    sink_stall_pct <= 10;
                end
            endcase
            target = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < target) begin
                make_random_file();
                send_file();
                if (ph == 0 && bytes_sent >= 50)
                    pressure_go = 1'b1;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        guard = 0;
        while (words_pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("** bom_detect_text_decoder: PASSED **");
        else
            $display("** bom_detect_text_decoder: FAILED **");
        $finish;
    end

endmodule
